/* hw/rtl/psc_pkg.sv */
// Shared constants and types for the pileup site classifier.
// Holds register indices, register reset values and the flag struct
// passed from the scale stage to the decision stage. No dependencies.
package psc_pkg;

    // Configuration port layout
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Register widths
    localparam int unsigned COV_W = 16;
    localparam int unsigned PCT_W = 7;

    // Register indices
    localparam logic [CFG_IDX_W-1:0] REG_COVERAGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRONG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INDEL    = 2'd2;

    // Register reset values
    localparam logic [COV_W-1:0] COV_RESET    = 16'd0;
    localparam logic [PCT_W-1:0] STRONG_RESET = 7'd95;
    localparam logic [PCT_W-1:0] INDEL_RESET  = 7'd25;

    // Count slots within one beat
    localparam int unsigned N_CNT     = 6;
    localparam int unsigned CNT_A     = 0;
    localparam int unsigned CNT_C     = 1;
    localparam int unsigned CNT_G     = 2;
    localparam int unsigned CNT_T     = 3;
    localparam int unsigned CNT_INS   = 4;
    localparam int unsigned CNT_DEL   = 5;

    // Rounding offset of a percentage threshold (half of 100)
    localparam int unsigned PCT_HALF = 50;

    // Flags resolved in the scale stage
    typedef struct packed {
        logic snp_site;   // SNP candidate
        logic cov_ok;     // peak count reaches a third of the estimate
    } t_scale_flags;

endpackage

/* hw/rtl/psc_pair_stage.sv */
// First pipeline stage: pairwise sums of the counts, max/min of each base pair and max of the indel pair.
// Depends on psc_pkg for the count slot indices.
module psc_pair_stage #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_valid,
    input  logic [psc_pkg::N_CNT-1:0][COUNT_BITS-1:0] i_cnt,
    output logic                                  o_valid,
    output logic [psc_pkg::N_CNT-1:0][COUNT_BITS-1:0] o_cnt,
    output logic [COUNT_BITS-1:0]                 o_hi_ac,
    output logic [COUNT_BITS-1:0]                 o_lo_ac,
    output logic [COUNT_BITS-1:0]                 o_hi_gt,
    output logic [COUNT_BITS-1:0]                 o_lo_gt,
    output logic [COUNT_BITS:0]                   o_sum_ac,
    output logic [COUNT_BITS:0]                   o_sum_gt,
    output logic [COUNT_BITS:0]                   o_sum_id,
    output logic [COUNT_BITS-1:0]                 o_peak_id
);

    logic                                      r_valid;
    logic [psc_pkg::N_CNT-1:0][COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0]                     r_hi_ac, r_lo_ac, r_hi_gt, r_lo_gt, r_peak_id;
    logic [COUNT_BITS:0]                       r_sum_ac, r_sum_gt, r_sum_id;

    logic [COUNT_BITS-1:0] n_hi_ac, n_lo_ac, n_hi_gt, n_lo_gt, n_peak_id;
    logic [COUNT_BITS:0]   n_sum_ac, n_sum_gt, n_sum_id;

    // Order each base pair, take the larger of the indel pair, add each pair
    always_comb begin
        logic [COUNT_BITS-1:0] a, c, g, t, ins, del;
        a   = i_cnt[psc_pkg::CNT_A];
        c   = i_cnt[psc_pkg::CNT_C];
        g   = i_cnt[psc_pkg::CNT_G];
        t   = i_cnt[psc_pkg::CNT_T];
        ins = i_cnt[psc_pkg::CNT_INS];
        del = i_cnt[psc_pkg::CNT_DEL];
        n_hi_ac   = (a >= c) ? a : c;
        n_lo_ac   = (a >= c) ? c : a;
        n_hi_gt   = (g >= t) ? g : t;
        n_lo_gt   = (g >= t) ? t : g;
        n_peak_id = (ins >= del) ? ins : del;
        n_sum_ac  = {1'b0, a} + {1'b0, c};
        n_sum_gt  = {1'b0, g} + {1'b0, t};
        n_sum_id  = {1'b0, ins} + {1'b0, del};
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cnt     <= i_cnt;
            r_hi_ac   <= n_hi_ac;
            r_lo_ac   <= n_lo_ac;
            r_hi_gt   <= n_hi_gt;
            r_lo_gt   <= n_lo_gt;
            r_peak_id <= n_peak_id;
            r_sum_ac  <= n_sum_ac;
            r_sum_gt  <= n_sum_gt;
            r_sum_id  <= n_sum_id;
        end
    end

    assign o_valid   = r_valid;
    assign o_cnt     = r_cnt;
    assign o_hi_ac   = r_hi_ac;
    assign o_lo_ac   = r_lo_ac;
    assign o_hi_gt   = r_hi_gt;
    assign o_lo_gt   = r_lo_gt;
    assign o_sum_ac  = r_sum_ac;
    assign o_sum_gt  = r_sum_gt;
    assign o_sum_id  = r_sum_id;
    assign o_peak_id = r_peak_id;

endmodule

/* hw/rtl/psc_rank_stage.sv */
// Second pipeline stage: total of all six counts, top and second base count,
// peak of all six counts. Depends on psc_pkg for the count slot count.
module psc_rank_stage #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_valid,
    input  logic [psc_pkg::N_CNT-1:0][COUNT_BITS-1:0] i_cnt,
    input  logic [COUNT_BITS-1:0]                 i_hi_ac,
    input  logic [COUNT_BITS-1:0]                 i_lo_ac,
    input  logic [COUNT_BITS-1:0]                 i_hi_gt,
    input  logic [COUNT_BITS-1:0]                 i_lo_gt,
    input  logic [COUNT_BITS:0]                   i_sum_ac,
    input  logic [COUNT_BITS:0]                   i_sum_gt,
    input  logic [COUNT_BITS:0]                   i_sum_id,
    input  logic [COUNT_BITS-1:0]                 i_peak_id,
    output logic                                  o_valid,
    output logic [psc_pkg::N_CNT-1:0][COUNT_BITS-1:0] o_cnt,
    output logic [COUNT_BITS+2:0]                 o_sum,
    output logic [COUNT_BITS-1:0]                 o_top,
    output logic [COUNT_BITS-1:0]                 o_second,
    output logic [COUNT_BITS-1:0]                 o_peak
);

    logic                                      r_valid;
    logic [psc_pkg::N_CNT-1:0][COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS+2:0]                     r_sum;
    logic [COUNT_BITS-1:0]                     r_top, r_second, r_peak;

    logic [COUNT_BITS+2:0] n_sum;
    logic [COUNT_BITS-1:0] n_top, n_second, n_peak;

    // Merge the two ordered base pairs, fold in the indel peak
    always_comb begin
        logic ac_wins;
        ac_wins  = (i_hi_ac >= i_hi_gt);
        n_top    = ac_wins ? i_hi_ac : i_hi_gt;
        if (ac_wins) begin
            n_second = (i_lo_ac >= i_hi_gt) ? i_lo_ac : i_hi_gt;
        end else begin
            n_second = (i_hi_ac >= i_lo_gt) ? i_hi_ac : i_lo_gt;
        end
        n_peak = (n_top >= i_peak_id) ? n_top : i_peak_id;
        n_sum  = {2'b00, i_sum_ac} + {2'b00, i_sum_gt} + {2'b00, i_sum_id};
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cnt    <= i_cnt;
            r_sum    <= n_sum;
            r_top    <= n_top;
            r_second <= n_second;
            r_peak   <= n_peak;
        end
    end

    assign o_valid  = r_valid;
    assign o_cnt    = r_cnt;
    assign o_sum    = r_sum;
    assign o_top    = r_top;
    assign o_second = r_second;
    assign o_peak   = r_peak;

endmodule

/* hw/rtl/psc_scale_stage.sv */
// Third pipeline stage: SNP ratio tests, coverage test, percentage products
// of the sum and counts scaled by 100. Depends on psc_pkg for widths and flags.
module psc_scale_stage #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  logic                                  i_valid,
    input  logic [psc_pkg::N_CNT-1:0][COUNT_BITS-1:0] i_cnt,
    input  logic [COUNT_BITS+2:0]                 i_sum,
    input  logic [COUNT_BITS-1:0]                 i_top,
    input  logic [COUNT_BITS-1:0]                 i_second,
    input  logic [COUNT_BITS-1:0]                 i_peak,
    input  logic [psc_pkg::COV_W-1:0]             i_coverage,
    input  logic [psc_pkg::PCT_W-1:0]             i_strong_pct,
    input  logic [psc_pkg::PCT_W-1:0]             i_indel_pct,
    output logic                                  o_valid,
    output psc_pkg::t_scale_flags                 o_flags,
    output logic [psc_pkg::N_CNT-1:0][COUNT_BITS+6:0] o_cnt100,
    output logic [COUNT_BITS+9:0]                 o_strong_prod,
    output logic [COUNT_BITS+9:0]                 o_indel_prod
);

    // Common compare width: holds 9*sum, pct*sum and the coverage estimate
    localparam int unsigned W  = COUNT_BITS + 10;
    localparam int unsigned SW = COUNT_BITS + 7;

    logic                                   r_valid;
    psc_pkg::t_scale_flags                  r_flags;
    logic [psc_pkg::N_CNT-1:0][SW-1:0]      r_cnt100;
    logic [W-1:0]                           r_strong_prod, r_indel_prod;

    psc_pkg::t_scale_flags                  n_flags;
    logic [psc_pkg::N_CNT-1:0][SW-1:0]      n_cnt100;
    logic [W-1:0]                           n_strong_prod, n_indel_prod;

    // SNP ratio tests and coverage test, all by shift-add scaling
    always_comb begin
        logic [W-1:0] sum_w, top_w, sec_w, pair_w, peak_w, cov_w;
        sum_w  = W'(i_sum);
        top_w  = W'(i_top);
        sec_w  = W'(i_second);
        pair_w = top_w + sec_w;
        peak_w = W'(i_peak);
        cov_w  = W'(i_coverage);
        n_flags.snp_site = ((sum_w << 1) > cov_w)
                        && (((top_w << 2) + top_w) < (sum_w << 2))
                        && (((sec_w << 2) + sec_w) > sum_w)
                        && (((pair_w << 3) + (pair_w << 1)) >= ((sum_w << 3) + sum_w));
        // peak < floor(estimate/3) is the same as 3*peak + 3 <= estimate
        n_flags.cov_ok = (((peak_w << 1) + peak_w + W'(3)) > cov_w);
    end

    // Percentage products of the sum
    assign n_strong_prod = W'(i_strong_pct) * W'(i_sum);
    assign n_indel_prod  = W'(i_indel_pct) * W'(i_sum);

    // Scale each count by 100
    always_comb begin
        for (int k = 0; k < psc_pkg::N_CNT; k++) begin
            n_cnt100[k] = (SW'(i_cnt[k]) << 6) + (SW'(i_cnt[k]) << 5) + (SW'(i_cnt[k]) << 2);
        end
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_flags       <= n_flags;
            r_cnt100      <= n_cnt100;
            r_strong_prod <= n_strong_prod;
            r_indel_prod  <= n_indel_prod;
        end
    end

    assign o_valid       = r_valid;
    assign o_flags       = r_flags;
    assign o_cnt100      = r_cnt100;
    assign o_strong_prod = r_strong_prod;
    assign o_indel_prod  = r_indel_prod;

endmodule

/* hw/rtl/pileup_site_classifier.sv */
// Pileup site classifier: four-stage pipeline from six counts to SNP and error flags.
// Throughput: one beat per cycle; each stage advances when it is empty or drains,
// so an output stall fills bubbles first and only then backs up the input.
// Reset (synchronous, active low) empties all stages and loads estimate 0,
// strong percent 95, indel percent 25. Depends on psc_pkg and the three stage modules.
module pileup_site_classifier #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // Configuration write port
    input  logic                                        i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [psc_pkg::CFG_DATA_W-1:0]              i_cfg_data,
    // Input stream
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // tdata from bit 0: count_a, count_c, count_g, count_t, count_insert,
    // count_delete (COUNT_BITS each), zero fill to whole bytes
    input  logic [((6*COUNT_BITS+7)/8)*8-1:0]           s_axis_tdata,
    // Output stream
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // tdata from bit 0: snp_site, error_site, zero fill
    output logic [7:0]                                  m_axis_tdata
);

    localparam int unsigned W  = COUNT_BITS + 10;
    localparam int unsigned SW = COUNT_BITS + 7;

    // Configuration registers
    logic [psc_pkg::COV_W-1:0] r_coverage;
    logic [psc_pkg::PCT_W-1:0] r_strong_pct;
    logic [psc_pkg::PCT_W-1:0] r_indel_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coverage   <= psc_pkg::COV_RESET;
            r_strong_pct <= psc_pkg::STRONG_RESET;
            r_indel_pct  <= psc_pkg::INDEL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                psc_pkg::REG_COVERAGE: r_coverage   <= i_cfg_data[psc_pkg::COV_W-1:0];
                psc_pkg::REG_STRONG:   r_strong_pct <= i_cfg_data[psc_pkg::PCT_W-1:0];
                psc_pkg::REG_INDEL:    r_indel_pct  <= i_cfg_data[psc_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the input beat
    logic [psc_pkg::N_CNT-1:0][COUNT_BITS-1:0] w_in_cnt;

    always_comb begin
        for (int k = 0; k < psc_pkg::N_CNT; k++) begin
            w_in_cnt[k] = s_axis_tdata[k*COUNT_BITS +: COUNT_BITS];
        end
    end

    // Stage advance chain: a stage moves when empty or when the next one moves
    logic w_adv_a, w_adv_b, w_adv_c, w_adv_d;
    logic w_valid_a, w_valid_b, w_valid_c;
    logic r_out_valid;

    assign w_adv_d = !r_out_valid || m_axis_tready;
    assign w_adv_c = !w_valid_c || w_adv_d;
    assign w_adv_b = !w_valid_b || w_adv_c;
    assign w_adv_a = !w_valid_a || w_adv_b;
    assign s_axis_tready = w_adv_a;

    // Stage A
    logic [psc_pkg::N_CNT-1:0][COUNT_BITS-1:0] w_cnt_a;
    logic [COUNT_BITS-1:0] w_hi_ac, w_lo_ac, w_hi_gt, w_lo_gt, w_peak_id;
    logic [COUNT_BITS:0]   w_sum_ac, w_sum_gt, w_sum_id;

    psc_pair_stage #(.COUNT_BITS(COUNT_BITS)) u_pair (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv_a),
        .i_valid   (s_axis_tvalid),
        .i_cnt     (w_in_cnt),
        .o_valid   (w_valid_a),
        .o_cnt     (w_cnt_a),
        .o_hi_ac   (w_hi_ac),
        .o_lo_ac   (w_lo_ac),
        .o_hi_gt   (w_hi_gt),
        .o_lo_gt   (w_lo_gt),
        .o_sum_ac  (w_sum_ac),
        .o_sum_gt  (w_sum_gt),
        .o_sum_id  (w_sum_id),
        .o_peak_id (w_peak_id)
    );

    // Stage B
    logic [psc_pkg::N_CNT-1:0][COUNT_BITS-1:0] w_cnt_b;
    logic [COUNT_BITS+2:0] w_sum;
    logic [COUNT_BITS-1:0] w_top, w_second, w_peak;

    psc_rank_stage #(.COUNT_BITS(COUNT_BITS)) u_rank (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv_b),
        .i_valid   (w_valid_a),
        .i_cnt     (w_cnt_a),
        .i_hi_ac   (w_hi_ac),
        .i_lo_ac   (w_lo_ac),
        .i_hi_gt   (w_hi_gt),
        .i_lo_gt   (w_lo_gt),
        .i_sum_ac  (w_sum_ac),
        .i_sum_gt  (w_sum_gt),
        .i_sum_id  (w_sum_id),
        .i_peak_id (w_peak_id),
        .o_valid   (w_valid_b),
        .o_cnt     (w_cnt_b),
        .o_sum     (w_sum),
        .o_top     (w_top),
        .o_second  (w_second),
        .o_peak    (w_peak)
    );

    // Stage C
    psc_pkg::t_scale_flags             w_flags;
    logic [psc_pkg::N_CNT-1:0][SW-1:0] w_cnt100;
    logic [W-1:0]                      w_strong_prod, w_indel_prod;

    psc_scale_stage #(.COUNT_BITS(COUNT_BITS)) u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv_c),
        .i_valid       (w_valid_b),
        .i_cnt         (w_cnt_b),
        .i_sum         (w_sum),
        .i_top         (w_top),
        .i_second      (w_second),
        .i_peak        (w_peak),
        .i_coverage    (r_coverage),
        .i_strong_pct  (r_strong_pct),
        .i_indel_pct   (r_indel_pct),
        .o_valid       (w_valid_c),
        .o_flags       (w_flags),
        .o_cnt100      (w_cnt100),
        .o_strong_prod (w_strong_prod),
        .o_indel_prod  (w_indel_prod)
    );

    // Stage D: threshold compares.
    // base < round(p*sum/100) is 100*c + 50 <= p*sum;
    // indel <= round(p*sum/100) is 100*c <= p*sum + 50.
    logic n_error;

    always_comb begin
        logic ok;
        ok = w_flags.cov_ok;
        for (int k = 0; k < psc_pkg::CNT_INS; k++) begin
            if ((W'(w_cnt100[k]) + W'(psc_pkg::PCT_HALF)) > w_strong_prod) begin
                ok = 1'b0;
            end
        end
        for (int k = psc_pkg::CNT_INS; k < psc_pkg::N_CNT; k++) begin
            if (W'(w_cnt100[k]) > (w_indel_prod + W'(psc_pkg::PCT_HALF))) begin
                ok = 1'b0;
            end
        end
        n_error = ok;
    end

    // Output register
    logic r_snp, r_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_d) begin
            r_out_valid <= w_valid_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_d) begin
            r_snp   <= w_flags.snp_site;
            r_error <= n_error;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_error, r_snp};

    // An empty output register never blocks the input
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input blocked while output register empty");

    // While the output stalls, the input is taken only if some stage holds a bubble
    a_stall_needs_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && s_axis_tready)
            |-> (!w_valid_a || !w_valid_b || !w_valid_c))
        else $error("full pipeline accepted a beat under output stall");

    // Reset leaves no result behind
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule
